// File: rtl/modulated_delay_chorus_assert.svh
// ----------------------------------------------------------------------------
// modulated_delay_chorus_assert.svh
// Assertion macros for the chorus block. The scope that uses them must have
// a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef MODULATED_DELAY_CHORUS_ASSERT_SVH
`define MODULATED_DELAY_CHORUS_ASSERT_SVH

// Implication within the same cycle, masked while reset is applied.
`define MDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, masked while reset is applied.
`define MDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset has been applied.
`define MDC_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Register map, reset values and fixed-point constants of the chorus block.
// ----------------------------------------------------------------------------
package mdc_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BYPASS     = 3'd0,
    REG_PHASE_STEP = 3'd1,
    REG_DEPTH      = 3'd2,
    REG_MIX        = 3'd3,
    REG_BASE_DELAY = 3'd4,
    REG_MOD_SPAN   = 3'd5
  } cfg_reg_t;

  // Register reset values.
  localparam logic [23:0] RST_PHASE_STEP = 24'd89478;
  localparam logic [16:0] RST_DEPTH      = 17'd32768;
  localparam logic [16:0] RST_MIX        = 17'd32768;
  localparam logic [11:0] RST_BASE_DELAY = 12'd480;
  localparam logic [9:0]  RST_MOD_SPAN   = 10'd240;

  // Unity in unsigned Q1.16.
  localparam logic [16:0] UNITY_Q16 = 17'h10000;

  // Quarter-wave sine polynomial coefficients, all Q16.
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;

  // Width of the second multiplier operand.
  localparam int MUL_B_BITS = 18;

endpackage

// File: rtl/mdc_store.sv
// ----------------------------------------------------------------------------
// mdc_store
// Delay line sample memory: one write port and one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module mdc_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// File: rtl/mdc_mul.sv
// ----------------------------------------------------------------------------
// mdc_mul
// Shared signed multiplier with a registered product. Every product of the
// sine polynomial, the modulation term, the interpolation and the mix passes
// through this one unit.
// ----------------------------------------------------------------------------
module mdc_mul #(
  parameter int A_BITS = 28,
  parameter int B_BITS = 18
) (
  input  logic                            clk,
  input  logic signed [A_BITS-1:0]        a,
  input  logic signed [B_BITS-1:0]        b,
  output logic signed [A_BITS+B_BITS-1:0] p_r
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// File: rtl/modulated_delay_chorus.sv
// ----------------------------------------------------------------------------
// modulated_delay_chorus: LFO-modulated delay line chorus, one sample per item.
// One item at a time: a new sample is taken only in the idle state, once the last
// result is in the output register, also in bypass; ten products go in turn
// through the single multiplier and both taps come from the one memory read port.
// Reset: synchronous; registers take their reset values and the delay line reads
// as silence until written, tracked by a wrap flag, so there is no clearing pass.
// ----------------------------------------------------------------------------
module modulated_delay_chorus #(
  parameter int DELAY_DEPTH  = 4096,
  parameter int SINE_ENTRIES = 1024,  // power of two
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_out,
  input  logic                                cfg_we,
  input  logic [mdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [mdc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int AW        = $clog2(DELAY_DEPTH);
  localparam int SINE_BITS = $clog2(SINE_ENTRIES);
  localparam int SB        = SAMPLE_BITS;
  localparam int WW        = SB + 9;
  localparam int MA        = (WW > 28) ? WW : 28;
  localparam int MB        = mdc_pkg::MUL_B_BITS;
  localparam int PW        = MA + MB;
  localparam int DW        = AW + 8;
  localparam int RW        = AW + 10;
  localparam int DSW       = (RW > 22) ? RW : 22;
  localparam int DRYW      = SB + 25;
  localparam int SUMW      = SB + 27;
  localparam int YW        = SB + 3;

  localparam logic [AW-1:0]          PTR_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [15:0]            XMASK    = 16'(32'hFFFF << (18 - SINE_BITS));
  localparam logic signed [DSW-1:0]  D_MAX    = DSW'((DELAY_DEPTH - 1) * 256);
  localparam logic signed [RW-1:0]   RP_WRAP  = RW'(DELAY_DEPTH * 256);
  localparam logic signed [PW-1:0]   RND_MOD  = PW'(2 ** 22);
  localparam logic signed [SUMW-1:0] RND_OUT  = SUMW'(2 ** 23);
  localparam logic signed [YW-1:0]   Y_MAX    = YW'(2 ** (SB - 1) - 1);
  localparam logic signed [YW-1:0]   Y_MIN    = YW'(-(2 ** (SB - 1)));

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_T1, S_T2, S_T3, S_M1, S_M2,
    S_ADDR, S_RD2, S_W1, S_W2, S_MX1, S_MX2, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic        bypass_r;
  logic [23:0] phase_step_r;
  logic [16:0] depth_r;
  logic [16:0] mix_r;
  logic [11:0] base_delay_r;
  logic [9:0]  mod_span_r;

  // Channel state.
  logic [AW-1:0] wp_r;
  logic          full_r;
  logic [31:0]   phase_r;

  // Per-item working registers.
  logic signed [SB-1:0]   x_r;
  logic                   byp_r;
  logic [1:0]             quad_r;
  logic [16:0]            xq_r;
  logic [16:0]            x2_r;
  logic signed [15:0]     sine_r;
  logic [DW-1:0]          d_r;
  logic [AW-1:0]          i1_r;
  logic [7:0]             f_r;
  logic                   vld1_r;
  logic                   vld2_r;
  logic signed [WW-1:0]   wet_part_r;
  logic signed [WW-1:0]   wet_r;
  logic signed [DRYW-1:0] dry_r;
  logic signed [SB-1:0]   y_r;
  logic                   out_valid_r;
  logic signed [SB-1:0]   out_data_r;

  // Combinational datapath.
  logic                   out_free;
  logic signed [MA-1:0]   mul_a;
  logic signed [MB-1:0]   mul_b;
  logic signed [PW-1:0]   prod_w;
  logic [15:0]            x16_w;
  logic [16:0]            xq_w;
  logic [16:0]            x2_w;
  logic [15:0]            t1_w;
  logic [16:0]            t2_w;
  logic [15:0]            t3_w;
  logic [14:0]            mag_w;
  logic signed [15:0]     sine_w;
  logic [16:0]            dep_w;
  logic [16:0]            mx_w;
  logic signed [PW-1:0]   mod_sum_w;
  logic signed [19:0]     mod_w;
  logic signed [DSW-1:0]  d_sum_w;
  logic [DW-1:0]          d_clamp_w;
  logic signed [RW-1:0]   rp_raw_w;
  logic signed [RW-1:0]   rp_w;
  logic [AW-1:0]          i1_w;
  logic [7:0]             f_w;
  logic [AW-1:0]          i2_w;
  logic [8:0]             nf_w;
  logic [AW-1:0]          rd_addr_w;
  logic [SB-1:0]          rd_data_w;
  logic signed [SB-1:0]   smp_w;
  logic signed [WW-1:0]   wet_w;
  logic signed [DRYW-1:0] dry_w;
  logic signed [SUMW-1:0] sum_w;
  logic signed [YW-1:0]   yfull_w;
  logic signed [SB-1:0]   ysat_w;

  // Shared multiplier and delay line memory.
  mdc_mul #(
    .A_BITS (MA),
    .B_BITS (MB)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_w)
  );

  mdc_store #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (SB)
  ) u_store (
    .clk       (clk),
    .wr_en     (state_r == S_W1),
    .wr_addr   (wp_r),
    .wr_data   (x_r),
    .rd_addr   (rd_addr_w),
    .rd_data_r (rd_data_w)
  );

  // Handshake.
  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign out_free       = !out_valid_r || out_ready;

  // Oversized depth and mix act as unity.
  assign dep_w = depth_r[16] ? mdc_pkg::UNITY_Q16 : depth_r;
  assign mx_w  = mix_r[16] ? mdc_pkg::UNITY_Q16 : mix_r;

  // Quarter-wave argument from the quantised phase, mirrored in odd quarters.
  assign x16_w = phase_r[29:14] & XMASK;
  assign xq_w  = phase_r[30] ? (mdc_pkg::UNITY_Q16 - {1'b0, x16_w}) : {1'b0, x16_w};

  // Polynomial steps, each taking the product registered in the cycle before.
  assign x2_w   = prod_w[32:16];
  assign t1_w   = mdc_pkg::SIN_B - {3'b000, prod_w[28:16]};
  assign t2_w   = mdc_pkg::SIN_A - {1'b0, prod_w[31:16]};
  assign t3_w   = prod_w[32:17];
  assign mag_w  = t3_w[15] ? 15'h7FFF : t3_w[14:0];
  assign sine_w = quad_r[1] ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});

  // Modulation term rounded to Q8 samples, added to the centre delay and clamped.
  assign mod_sum_w = prod_w + RND_MOD;
  assign mod_w     = mod_sum_w[42:23];
  assign d_sum_w   = DSW'($signed({1'b0, base_delay_r, 8'h00})) + DSW'(mod_w);

  always_comb begin
    if (d_sum_w[DSW-1]) begin
      d_clamp_w = '0;
    end else if (d_sum_w > D_MAX) begin
      d_clamp_w = D_MAX[DW-1:0];
    end else begin
      d_clamp_w = d_sum_w[DW-1:0];
    end
  end

  // Read position behind the write pointer, wrapped into the line.
  assign rp_raw_w = $signed({2'b00, wp_r, 8'h00}) - $signed({2'b00, d_r});
  assign rp_w     = rp_raw_w[RW-1] ? (rp_raw_w + RP_WRAP) : rp_raw_w;
  assign i1_w     = rp_w[DW-1:8];
  assign f_w      = rp_w[7:0];
  assign i2_w     = (i1_r == PTR_LAST) ? '0 : (i1_r + 1'b1);
  assign nf_w     = 9'h100 - {1'b0, f_r};
  assign rd_addr_w = (state_r == S_RD2) ? i2_w : i1_w;

  // An entry not yet written since reset reads as silence.
  always_comb begin
    if ((state_r == S_RD2) ? vld1_r : vld2_r) begin
      smp_w = $signed(rd_data_w);
    end else begin
      smp_w = '0;
    end
  end

  // Interpolation sum, dry term and the rounded, saturated mix.
  assign wet_w   = wet_part_r + $signed(prod_w[WW-1:0]);
  assign dry_w   = $signed({prod_w[SB+16:0], 8'h00});
  assign sum_w   = SUMW'(dry_r) + SUMW'($signed(prod_w[SB+25:0])) + RND_OUT;
  assign yfull_w = sum_w[SUMW-1:24];

  always_comb begin
    if (yfull_w > Y_MAX) begin
      ysat_w = Y_MAX[SB-1:0];
    end else if (yfull_w < Y_MIN) begin
      ysat_w = Y_MIN[SB-1:0];
    end else begin
      ysat_w = yfull_w[SB-1:0];
    end
  end

  // Multiplier operands, at most one product per sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_IDLE: begin
        mul_a = MA'({1'b0, xq_w});
        mul_b = {1'b0, xq_w};
      end
      S_SQ: begin
        mul_a = MA'(mdc_pkg::SIN_C);
        mul_b = {1'b0, x2_w};
      end
      S_T1: begin
        mul_a = MA'(t1_w);
        mul_b = {1'b0, x2_r};
      end
      S_T2: begin
        mul_a = MA'(t2_w);
        mul_b = {1'b0, xq_r};
      end
      S_T3: begin
        mul_a = MA'(mod_span_r);
        mul_b = {1'b0, dep_w};
      end
      S_M1: begin
        mul_a = MA'({1'b0, prod_w[25:0]});
        mul_b = MB'(sine_r);
      end
      S_RD2: begin
        mul_a = MA'(smp_w);
        mul_b = {9'b0, nf_w};
      end
      S_W1: begin
        mul_a = MA'(smp_w);
        mul_b = {10'b0, f_r};
      end
      S_W2: begin
        mul_a = MA'(x_r);
        mul_b = {1'b0, mdc_pkg::UNITY_Q16 - mx_w};
      end
      S_MX1: begin
        mul_a = MA'(wet_r);
        mul_b = {1'b0, mx_w};
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = bypass_r ? S_OUT : S_SQ;
        end
      end
      S_SQ:   state_nxt = S_T1;
      S_T1:   state_nxt = S_T2;
      S_T2:   state_nxt = S_T3;
      S_T3:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_RD2;
      S_RD2:  state_nxt = S_W1;
      S_W1:   state_nxt = S_W2;
      S_W2:   state_nxt = S_MX1;
      S_MX1:  state_nxt = S_MX2;
      S_MX2:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer state, working registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      phase_r     <= '0;
    end else begin
      state_r <= state_nxt;
      // The output step below loads a fresh result in its own state.
      if (out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r    <= in_sample_in;
            y_r    <= in_sample_in;
            byp_r  <= bypass_r;
            xq_r   <= xq_w;
            quad_r <= phase_r[31:30];
          end
        end
        S_SQ:   x2_r   <= x2_w;
        S_T3:   sine_r <= sine_w;
        S_M2:   d_r    <= d_clamp_w;
        S_ADDR: begin
          i1_r   <= i1_w;
          f_r    <= f_w;
          vld1_r <= full_r || (i1_w < wp_r);
        end
        S_RD2:  vld2_r     <= full_r || (i2_w < wp_r);
        S_W1:   wet_part_r <= $signed(prod_w[WW-1:0]);
        S_W2:   wet_r      <= wet_w;
        S_MX1:  dry_r      <= dry_w;
        S_MX2:  y_r        <= ysat_w;
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= y_r;
            // Advance the line and the LFO only for processed samples.
            if (!byp_r) begin
              phase_r <= phase_r + {8'h00, phase_step_r};
              wp_r    <= (wp_r == PTR_LAST) ? '0 : (wp_r + 1'b1);
              full_r  <= full_r || (wp_r == PTR_LAST);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r     <= 1'b0;
      phase_step_r <= mdc_pkg::RST_PHASE_STEP;
      depth_r      <= mdc_pkg::RST_DEPTH;
      mix_r        <= mdc_pkg::RST_MIX;
      base_delay_r <= mdc_pkg::RST_BASE_DELAY;
      mod_span_r   <= mdc_pkg::RST_MOD_SPAN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdc_pkg::REG_BYPASS:     bypass_r     <= cfg_wdata[0];
        mdc_pkg::REG_PHASE_STEP: phase_step_r <= cfg_wdata[23:0];
        mdc_pkg::REG_DEPTH:      depth_r      <= cfg_wdata[16:0];
        mdc_pkg::REG_MIX:        mix_r        <= cfg_wdata[16:0];
        mdc_pkg::REG_BASE_DELAY: base_delay_r <= cfg_wdata[11:0];
        mdc_pkg::REG_MOD_SPAN:   mod_span_r   <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/mdc_checker.sv
// ----------------------------------------------------------------------------
// mdc_checker
// Port-level checks of the chorus block: output hold, one item in flight, results
// only after work and the reset state of both channels.
// ----------------------------------------------------------------------------
`include "modulated_delay_chorus_assert.svh"

module mdc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample_out
);

  // A result waiting for transfer keeps its value.
  `MDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_out), "output changed while stalled")

  // Once an item is taken, no further item is taken until it is finished.
  `MDC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")

  // A new result only appears after the block has been busy with an item.
  `MDC_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(!in_ready), "result without work")

  // After reset the block is empty and ready.
  `MDC_ASSERT_RST(a_reset_state, !out_valid && in_ready, "bad state after reset")

endmodule

bind modulated_delay_chorus mdc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mdc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the modulated delay chorus
// Drives samples through the valid/ready input channel and predicts every
// output sample with a bit-exact model of the LFO, the delay line, the
// interpolated tap and the dry/wet mix. Registers are rewritten between
// phases while the block is idle. A short directed part comes first, then
// randomised phases under changing backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int LINE_DEPTH  = 4096;
  localparam int SINE_N      = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_IDX_W   = mdc_pkg::CFG_IDX_BITS;
  localparam int CFG_DATA_W  = mdc_pkg::CFG_DATA_BITS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1350;
  localparam int IDLE_SWAP_AT = 450;
  localparam int IDLE_OFF_AT  = 900;

  // Register indexes beyond the map; writes to them must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [SAMPLE_W-1:0]     in_sample_in = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]     out_sample_out;
  logic                           cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_wdata = '0;

  int send_idle_pct = 13;
  int recv_idle_pct = 71;
  int n_sent = 0;
  int n_cycles = 0;

  modulated_delay_chorus #(
    .DELAY_DEPTH (LINE_DEPTH),
    .SINE_ENTRIES(SINE_N),
    .SAMPLE_BITS (SAMPLE_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Predicts the chorus output for each accepted sample and checks results
  // in order against the samples still due.
  class chorus_scoreboard;
    logic                       bypass_q;
    logic [23:0]                phase_step_q;
    logic [16:0]                depth_q;
    logic [16:0]                mix_q;
    logic [11:0]                base_delay_q;
    logic [9:0]                 mod_span_q;
    logic signed [SAMPLE_W-1:0] history [LINE_DEPTH];
    int                         write_ptr;
    logic [31:0]                lfo_phase;
    logic signed [SAMPLE_W-1:0] due_samples [$];
    int                         n_errors;

    function new();
      bypass_q     = 1'b0;
      phase_step_q = mdc_pkg::RST_PHASE_STEP;
      depth_q      = mdc_pkg::RST_DEPTH;
      mix_q        = mdc_pkg::RST_MIX;
      base_delay_q = mdc_pkg::RST_BASE_DELAY;
      mod_span_q   = mdc_pkg::RST_MOD_SPAN;
      foreach (history[i]) history[i] = '0;
      write_ptr = 0;
      lfo_phase = '0;
      n_errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        mdc_pkg::REG_BYPASS:     bypass_q     = data[0];
        mdc_pkg::REG_PHASE_STEP: phase_step_q = data[23:0];
        mdc_pkg::REG_DEPTH:      depth_q      = data[16:0];
        mdc_pkg::REG_MIX:        mix_q        = data[16:0];
        mdc_pkg::REG_BASE_DELAY: base_delay_q = data[11:0];
        mdc_pkg::REG_MOD_SPAN:   mod_span_q   = data[9:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] x);
      longint unsigned idx, p, u, u2, t;
      longint sine, dep, mx, d, rp, i1, i2, f, wet8, y;
      if (bypass_q) begin
        due_samples.push_back(x);
        return;
      end
      // Quarter-wave polynomial sine on the quantised phase, Q15.
      idx = ({32'd0, lfo_phase} * SINE_N) >> 32;
      p = ((idx << 32) / SINE_N) & 64'hFFFF_FFFF;
      u = (p & 64'h3FFF_FFFF) >> 14;
      if (p[30]) begin
        u = 64'd65536 - u;
      end
      u2 = (u * u) >> 16;
      t = (mdc_pkg::SIN_C * u2) >> 16;
      t = mdc_pkg::SIN_B - t;
      t = (t * u2) >> 16;
      t = mdc_pkg::SIN_A - t;
      t = ((t * u) >> 16) >> 1;
      if (t > 32767) begin
        t = 32767;
      end
      sine = p[31] ? -longint'(t) : longint'(t);

      dep = (depth_q > mdc_pkg::UNITY_Q16) ? mdc_pkg::UNITY_Q16 : depth_q;
      mx  = (mix_q > mdc_pkg::UNITY_Q16) ? mdc_pkg::UNITY_Q16 : mix_q;

      // Delay in Q8 samples, held within the line.
      d = longint'(base_delay_q) * 256 +
          ((longint'(mod_span_q) * dep * sine + 4194304) >>> 23);
      if (d < 0) begin
        d = 0;
      end
      if (d > (LINE_DEPTH - 1) * 256) begin
        d = (LINE_DEPTH - 1) * 256;
      end

      // Interpolated tap, read before the new sample is stored.
      rp = longint'(write_ptr) * 256 - d;
      if (rp < 0) begin
        rp = rp + LINE_DEPTH * 256;
      end
      i1 = (rp >>> 8) % LINE_DEPTH;
      f  = rp % 256;
      i2 = (i1 + 1) % LINE_DEPTH;
      wet8 = history[i1] * (256 - f) + history[i2] * f;

      history[write_ptr] = x;
      write_ptr = (write_ptr + 1) % LINE_DEPTH;

      // Dry/wet mix with rounding and saturation.
      y = (longint'(x) * 256 * (65536 - mx) + wet8 * mx + 8388608) >>> 24;
      if (y > 32767) begin
        y = 32767;
      end
      if (y < -32768) begin
        y = -32768;
      end
      due_samples.push_back(SAMPLE_W'(y));
      lfo_phase = lfo_phase + {8'd0, phase_step_q};
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (due_samples.size() == 0) begin
        $error("sample_out: expected nothing, actual %0d", got);
        n_errors++;
      end else begin
        want = due_samples.pop_front();
        if (got !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, got);
          n_errors++;
        end
      end
    endfunction
  endclass

  chorus_scoreboard sb;

  // Clock.
  always #10 clk = ~clk;

  // Result side readiness, idling at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Observe register writes and transfers on both channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.set_reg(cfg_index, cfg_wdata);
      end
      if (in_valid && in_ready) begin
        sb.take_sample(in_sample_in);
      end
      if (out_valid && out_ready) begin
        sb.check_sample(out_sample_out);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offer one sample and return at the edge of its transfer. Valid is left
  // high so that a following sample can go without a gap.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    if (n_sent < IDLE_SWAP_AT) begin
      send_idle_pct = 13;
      recv_idle_pct = 71;
    end else if (n_sent < IDLE_OFF_AT) begin
      send_idle_pct = 71;
      recv_idle_pct = 13;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // One register write; the caller lowers the write enable after the last.
  // Narrow registers sometimes carry junk in the unused upper data bits.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    if ($urandom_range(1) == 1) begin
      value = value | (CFG_DATA_W'($urandom) << width);
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Stop offering and wait until every due sample has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_samples.size() != 0) @(posedge clk);
  endtask

  // New register settings for a random phase, extremes included.
  task automatic setup_random();
    logic [23:0] step;
    logic [16:0] dep;
    logic [16:0] mx;
    logic [11:0] base;
    logic [9:0]  span;
    case ($urandom_range(4))
      0:       step = '0;
      1:       step = 24'hFF_FFFF;
      2:       step = 24'($urandom_range(1, 65535));
      default: step = 24'($urandom);
    endcase
    case ($urandom_range(5))
      0:       dep = '0;
      1:       dep = mdc_pkg::UNITY_Q16;
      2:       dep = 17'($urandom_range(65537, 131071));
      default: dep = 17'($urandom_range(65536));
    endcase
    case ($urandom_range(5))
      0:       mx = '0;
      1:       mx = mdc_pkg::UNITY_Q16;
      2:       mx = 17'($urandom_range(65537, 131071));
      default: mx = 17'($urandom_range(65536));
    endcase
    // Mostly short delays so that the tap lands on recently written samples.
    case ($urandom_range(7))
      0:       base = '0;
      1:       base = 12'd4094;
      2:       base = 12'hFFF;
      3:       base = 12'($urandom);
      default: base = 12'($urandom_range(40));
    endcase
    case ($urandom_range(3))
      0:       span = '0;
      1:       span = 10'h3FF;
      default: span = 10'($urandom);
    endcase
    write_reg(mdc_pkg::REG_BYPASS, CFG_DATA_W'($urandom_range(99) < 12), 1);
    write_reg(mdc_pkg::REG_PHASE_STEP, step, 24);
    write_reg(mdc_pkg::REG_DEPTH, CFG_DATA_W'(dep), 17);
    write_reg(mdc_pkg::REG_MIX, CFG_DATA_W'(mx), 17);
    write_reg(mdc_pkg::REG_BASE_DELAY, CFG_DATA_W'(base), 12);
    write_reg(mdc_pkg::REG_MOD_SPAN, CFG_DATA_W'(span), 10);
    if ($urandom_range(4) == 0) begin
      write_reg(($urandom_range(1) == 1) ? REG_SPARE_LO : REG_SPARE_HI,
                CFG_DATA_W'($urandom), CFG_DATA_W);
    end
    cfg_we <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    int n_random;
    int phase_len;
    logic signed [SAMPLE_W-1:0] s;
    sb = new();
    n_random = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings with the sample extremes.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
    wait_idle();

    // Bypass: straight through, state left alone.
    write_reg(mdc_pkg::REG_BYPASS, 24'd1, 1);
    cfg_we <= 1'b0;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh2AD5);
    wait_idle();

    // Zero delay: the tap reads the slot about to be overwritten.
    write_reg(mdc_pkg::REG_BYPASS, 24'd0, 1);
    write_reg(mdc_pkg::REG_BASE_DELAY, 24'd0, 12);
    write_reg(mdc_pkg::REG_MOD_SPAN, 24'd0, 10);
    cfg_we <= 1'b0;
    send_sample(16'sh4000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    wait_idle();

    // Delay beyond the line, oversized depth and mix, fastest LFO.
    write_reg(mdc_pkg::REG_BASE_DELAY, 24'hFFF, 12);
    write_reg(mdc_pkg::REG_MOD_SPAN, 24'h3FF, 10);
    write_reg(mdc_pkg::REG_DEPTH, 24'h1_FFFF, 17);
    write_reg(mdc_pkg::REG_MIX, 24'h1_FFFF, 17);
    write_reg(mdc_pkg::REG_PHASE_STEP, 24'hFF_FFFF, 24);
    cfg_we <= 1'b0;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    send_sample(16'shEDCB);
    wait_idle();

    // Full swing about a zero centre, dry path only; spare indexes ignored.
    write_reg(mdc_pkg::REG_BASE_DELAY, 24'd0, 12);
    write_reg(mdc_pkg::REG_DEPTH, CFG_DATA_W'(mdc_pkg::UNITY_Q16), 17);
    write_reg(mdc_pkg::REG_MIX, 24'd0, 17);
    write_reg(REG_SPARE_LO, 24'hFF_FFFF, CFG_DATA_W);
    write_reg(REG_SPARE_HI, 24'hA5_A5A5, CFG_DATA_W);
    cfg_we <= 1'b0;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh5A5A);
    wait_idle();

    // Random phases, each under fresh settings.
    while (n_random < RANDOM_ITEMS) begin
      setup_random();
      phase_len = $urandom_range(15, 90);
      repeat (phase_len) begin
        case ($urandom_range(9))
          0:       s = ($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000;
          1:       s = SAMPLE_W'($urandom_range(511)) - 16'sd256;
          default: s = SAMPLE_W'($urandom);
        endcase
        send_sample(s);
        n_random++;
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.due_samples.size() != 0) begin
      $error("sample_out: expected %0d more, actual none", sb.due_samples.size());
      sb.n_errors++;
    end
    if (sb.n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
